// ===== hdl/ptfe_pkg.sv =====
`timescale 1ns / 1ps
// ptfe_pkg: action and status codes, field widths and the result beat type
// shared by the pipe table engine modules; no dependencies

package ptfe_pkg;

   localparam int ACTION_W = 3;
   localparam int INDEX_W  = 3;
   localparam int BYTE_W   = 8;
   localparam int RCOUNT_W = 5;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 4;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 4'd15;

   localparam logic [ACTION_W-1:0] ACT_ALLOC = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_READ  = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_WRITE = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_CLOSE = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_DUP   = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
   localparam logic [STATUS_W-1:0] ST_EOF     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_BLOCK   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_BROKEN  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOFREE  = 3'd4;
   localparam logic [STATUS_W-1:0] ST_INVALID = 3'd5;
   localparam logic [STATUS_W-1:0] ST_UNDER   = 3'd6;
   localparam logic [STATUS_W-1:0] ST_OVER    = 3'd7;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [BYTE_W-1:0]   read_byte;
      logic                byte_valid;
      logic                last;
      logic [INDEX_W-1:0]  alloc_index;
      logic                write_done;
   } rsp_beat_type;

   typedef struct packed {
      logic set;
      logic clear;
   } slot_cmd_type;

endpackage

// ===== hdl/pipe_table_fifo_engine.sv =====
`timescale 1ns / 1ps
// pipe_table_fifo_engine: top level of the pipe table, holding the slot record
// and byte memories and the action sequencer; depends on ptfe_pkg,
// ptfe_slot_alloc and ptfe_rsp_buf

// One action is taken at a time. Alloc, write, close, dup, and any read that
// returns no data first read the slot record from its memory, then decide,
// answer and write it back. A read returning n bytes then sends n beats out
// of the byte memory and its single registered read port, one beat per cycle
// unless rsp_ready holds a beat back. Both memories need no clearing after
// reset: a slot record is only read after alloc has written it, and only bytes
// written since alloc are ever returned.

module pipe_table_fifo_engine #(
   parameter int PIPE_SLOTS   = 8,
   parameter int BUFFER_BYTES = 512,
   parameter int READ_MAX     = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_action,
   input  logic [2:0] req_pipe_index,
   input  logic       req_write_end,
   input  logic [7:0] req_write_byte,
   input  logic [4:0] req_read_count,
   input  logic       req_last_of_write,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_status,
   output logic [7:0] rsp_read_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_last,
   output logic [2:0] rsp_alloc_index,
   output logic       rsp_write_done
);
   import ptfe_pkg::*;

   localparam int SLOT_W     = (PIPE_SLOTS > 1) ? $clog2(PIPE_SLOTS) : 1;
   localparam int OFF_W      = $clog2(BUFFER_BYTES);
   localparam int BYTE_DEPTH = PIPE_SLOTS * BUFFER_BYTES;
   localparam int BADDR_W    = $clog2(BYTE_DEPTH);
   localparam int RC_W       = $clog2(READ_MAX + 1);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_DECIDE = 2'd1;
   localparam logic [1:0] S_READ   = 2'd2;

   typedef struct packed {
      logic             wrap;
      logic [OFF_W-1:0] off;
   } ptr_type;

   typedef struct packed {
      ptr_type            rp;
      ptr_type            wp;
      logic [COUNT_W-1:0] readers;
      logic [COUNT_W-1:0] writers;
   } meta_type;

   function automatic ptr_type ptr_inc(ptr_type p);
      ptr_type n;
      n = p;
      if (p.off == OFF_W'(BUFFER_BYTES - 1)) begin
         n.off  = '0;
         n.wrap = ~p.wrap;
      end else begin
         n.off = p.off + 1'b1;
      end
      return n;
   endfunction

   function automatic logic [BADDR_W-1:0] byte_addr(logic [SLOT_W-1:0] s,
                                                    logic [OFF_W-1:0] o);
      return BADDR_W'(s) * BADDR_W'(BUFFER_BYTES) + BADDR_W'(o);
   endfunction

   // sequencer state and latched request
   logic [1:0]          state_ff, state_in;
   logic [ACTION_W-1:0] action_ff;
   logic                write_end_ff;
   logic [BYTE_W-1:0]   wbyte_ff;
   logic [RCOUNT_W-1:0] rcount_ff;
   logic                lastw_ff;
   logic                idx_ok_ff;
   logic [SLOT_W-1:0]   slot_ff;
   ptr_type             rp_ff, rp_in;
   logic [RC_W-1:0]     rem_ff, rem_in;

   logic                req_fire;
   logic                idx_ok;
   logic [SLOT_W-1:0]   slot_sel;

   // memories
   meta_type            meta_mem [PIPE_SLOTS];
   meta_type            meta_q;
   logic [SLOT_W-1:0]   meta_raddr;
   logic                meta_we;
   logic [SLOT_W-1:0]   meta_waddr;
   meta_type            meta_wdata;

   logic [BYTE_W-1:0]   byte_mem [BYTE_DEPTH];
   logic [BYTE_W-1:0]   byte_q;
   logic [BADDR_W-1:0]  byte_raddr;
   logic                byte_we;
   logic [BADDR_W-1:0]  byte_waddr;

   // slot flags and result register
   slot_cmd_type        scmd;
   logic [SLOT_W-1:0]   scmd_slot;
   logic [PIPE_SLOTS-1:0] in_use;
   logic                free_found;
   logic [SLOT_W-1:0]   free_slot;
   logic                push;
   rsp_beat_type        beat;
   logic                rsp_free;

   // decode helpers
   logic                in_use_hit;
   logic                empty;
   logic                full;
   logic [COUNT_W-1:0]  cnt_sel;
   logic [COUNT_W-1:0]  cnt_other;
   logic [COUNT_W-1:0]  cnt_new;
   logic [RC_W-1:0]     rc_cap;
   ptr_type             rp_nx;
   logic                read_last;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign idx_ok    = 32'(req_pipe_index) < PIPE_SLOTS;
   assign slot_sel  = idx_ok ? SLOT_W'(req_pipe_index) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         action_ff    <= req_action;
         write_end_ff <= req_write_end;
         wbyte_ff     <= req_write_byte;
         rcount_ff    <= req_read_count;
         lastw_ff     <= req_last_of_write;
         idx_ok_ff    <= idx_ok;
         slot_ff      <= slot_sel;
      end
      rp_ff  <= rp_in;
      rem_ff <= rem_in;
   end

   // record memory: read address follows the request in idle, then holds
   assign meta_raddr = (state_ff == S_IDLE) ? slot_sel : slot_ff;

   always_ff @(posedge clock) begin
      if (meta_we) begin
         meta_mem[meta_waddr] <= meta_wdata;
      end
      meta_q <= meta_mem[meta_raddr];
   end

   always_ff @(posedge clock) begin
      if (byte_we) begin
         byte_mem[byte_waddr] <= wbyte_ff;
      end
      byte_q <= byte_mem[byte_raddr];
   end

   assign in_use_hit = idx_ok_ff && in_use[slot_ff];
   assign empty      = (meta_q.rp == meta_q.wp);
   assign full       = (meta_q.rp.wrap != meta_q.wp.wrap) && (meta_q.rp.off == meta_q.wp.off);
   assign cnt_sel    = write_end_ff ? meta_q.writers : meta_q.readers;
   assign cnt_other  = write_end_ff ? meta_q.readers : meta_q.writers;
   assign rc_cap     = (32'(rcount_ff) > READ_MAX) ? RC_W'(READ_MAX) : RC_W'(rcount_ff);
   assign rp_nx      = ptr_inc(rp_ff);
   assign read_last  = (rem_ff == RC_W'(1)) || (rp_nx == meta_q.wp);

   always_comb begin
      state_in   = state_ff;
      push       = 1'b0;
      beat       = '0;
      beat.last  = 1'b1;
      meta_we    = 1'b0;
      meta_waddr = slot_ff;
      meta_wdata = meta_q;
      byte_we    = 1'b0;
      byte_waddr = byte_addr(slot_ff, meta_q.wp.off);
      byte_raddr = byte_addr(slot_ff, rp_ff.off);
      scmd       = '0;
      scmd_slot  = slot_ff;
      rp_in      = rp_ff;
      rem_in     = rem_ff;
      cnt_new    = cnt_sel;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (action_ff == ACT_READ && in_use_hit && rcount_ff != '0 && !empty) begin
               state_in   = S_READ;
               rp_in      = meta_q.rp;
               rem_in     = rc_cap;
               byte_raddr = byte_addr(slot_ff, meta_q.rp.off);
            end else if (rsp_free) begin
               push     = 1'b1;
               state_in = S_IDLE;
               priority if (action_ff == ACT_ALLOC) begin
                  if (free_found) begin
                     beat.status        = ST_OK;
                     beat.alloc_index   = INDEX_W'(free_slot);
                     meta_we            = 1'b1;
                     meta_waddr         = free_slot;
                     meta_wdata.rp      = '0;
                     meta_wdata.wp      = '0;
                     meta_wdata.readers = COUNT_W'(1);
                     meta_wdata.writers = COUNT_W'(1);
                     scmd.set           = 1'b1;
                     scmd_slot          = free_slot;
                  end else begin
                     beat.status = ST_NOFREE;
                  end
               end else if (action_ff > ACT_DUP || !in_use_hit) begin
                  beat.status = ST_INVALID;
               end else if (action_ff == ACT_READ) begin
                  if (rcount_ff == '0) begin
                     beat.status = ST_INVALID;
                  end else begin
                     beat.status = (meta_q.writers == '0) ? ST_EOF : ST_BLOCK;
                  end
               end else if (action_ff == ACT_WRITE) begin
                  if (meta_q.readers == '0) begin
                     beat.status = ST_BROKEN;
                  end else if (full) begin
                     beat.status = ST_BLOCK;
                  end else begin
                     beat.status     = ST_OK;
                     beat.write_done = lastw_ff;
                     byte_we         = 1'b1;
                     meta_we         = 1'b1;
                     meta_wdata.wp   = ptr_inc(meta_q.wp);
                  end
               end else if (action_ff == ACT_CLOSE) begin
                  if (cnt_sel == '0) begin
                     beat.status = ST_UNDER;
                  end else begin
                     beat.status = ST_OK;
                     cnt_new     = cnt_sel - 1'b1;
                     meta_we     = 1'b1;
                     if (write_end_ff) begin
                        meta_wdata.writers = cnt_new;
                     end else begin
                        meta_wdata.readers = cnt_new;
                     end
                     if (cnt_new == '0 && cnt_other == '0) begin
                        scmd.clear = 1'b1;
                     end
                  end
               end else begin
                  if (cnt_sel == COUNT_MAX) begin
                     beat.status = ST_OVER;
                  end else begin
                     beat.status = ST_OK;
                     cnt_new     = cnt_sel + 1'b1;
                     meta_we     = 1'b1;
                     if (write_end_ff) begin
                        meta_wdata.writers = cnt_new;
                     end else begin
                        meta_wdata.readers = cnt_new;
                     end
                  end
               end
            end
         end
         S_READ: begin
            if (rsp_free) begin
               push            = 1'b1;
               beat.status     = ST_OK;
               beat.read_byte  = byte_q;
               beat.byte_valid = 1'b1;
               beat.last       = read_last;
               rp_in           = rp_nx;
               rem_in          = rem_ff - 1'b1;
               // prefetch the next byte while this beat goes out
               byte_raddr      = byte_addr(slot_ff, rp_nx.off);
               if (read_last) begin
                  meta_we       = 1'b1;
                  meta_wdata.rp = rp_nx;
                  state_in      = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   ptfe_slot_alloc #(
      .PIPE_SLOTS (PIPE_SLOTS),
      .SLOT_W     (SLOT_W)
   ) u_slot_alloc (
      .clock      (clock),
      .reset      (reset),
      .cmd        (scmd),
      .cmd_slot   (scmd_slot),
      .in_use     (in_use),
      .free_found (free_found),
      .free_slot  (free_slot)
   );

   ptfe_rsp_buf u_rsp_buf (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .beat_in         (beat),
      .free            (rsp_free),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_read_byte   (rsp_read_byte),
      .rsp_byte_valid  (rsp_byte_valid),
      .rsp_last        (rsp_last),
      .rsp_alloc_index (rsp_alloc_index),
      .rsp_write_done  (rsp_write_done)
   );

   a_accept_decides: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == S_DECIDE)
      else $error("accepted action not decided next cycle");

   a_read_rem: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_READ |-> rem_ff != '0)
      else $error("read loop running with nothing left to return");

   a_read_not_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_READ |-> rp_ff != meta_q.wp)
      else $error("read loop past the write pointer");

   a_push_busy: assert property (@(posedge clock) disable iff (reset)
      push |-> state_ff != S_IDLE && rsp_free)
      else $error("result beat pushed while idle or blocked");

endmodule

// ===== hdl/ptfe_slot_alloc.sv =====
`timescale 1ns / 1ps
// ptfe_slot_alloc: in-use flags of the pipe slots and a registered search
// for the lowest free slot; depends on ptfe_pkg

module ptfe_slot_alloc #(
   parameter int PIPE_SLOTS = 8,
   parameter int SLOT_W     = 3
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ptfe_pkg::slot_cmd_type cmd,
   input  logic [SLOT_W-1:0]     cmd_slot,
   output logic [PIPE_SLOTS-1:0] in_use,
   output logic                  free_found,
   output logic [SLOT_W-1:0]     free_slot
);
   import ptfe_pkg::*;

   logic [PIPE_SLOTS-1:0] in_use_ff, in_use_in;
   logic                  free_found_ff, free_found_in;
   logic [SLOT_W-1:0]     free_slot_ff, free_slot_in;

   always_comb begin
      in_use_in = in_use_ff;
      if (cmd.set) begin
         in_use_in[cmd_slot] = 1'b1;
      end else if (cmd.clear) begin
         in_use_in[cmd_slot] = 1'b0;
      end
   end

   // lowest free slot wins
   always_comb begin
      free_found_in = 1'b0;
      free_slot_in  = '0;
      for (int i = PIPE_SLOTS - 1; i >= 0; i--) begin
         if (!in_use_ff[i]) begin
            free_found_in = 1'b1;
            free_slot_in  = SLOT_W'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_use_ff     <= '0;
         free_found_ff <= 1'b0;
      end else begin
         in_use_ff     <= in_use_in;
         free_found_ff <= free_found_in;
      end
   end

   always_ff @(posedge clock) begin
      free_slot_ff <= free_slot_in;
   end

   assign in_use     = in_use_ff;
   assign free_found = free_found_ff;
   assign free_slot  = free_slot_ff;

   a_set_clear_excl: assert property (@(posedge clock) disable iff (reset)
      cmd.set |-> !cmd.clear)
      else $error("slot set and clear together");

   a_set_takes: assert property (@(posedge clock) disable iff (reset)
      cmd.set |=> in_use_ff[$past(cmd_slot)])
      else $error("allocated slot not marked in use");

   a_free_is_free: assert property (@(posedge clock) disable iff (reset)
      free_found_ff |-> (!in_use_ff[free_slot_ff] || $past(cmd.set)))
      else $error("free slot search points at a slot in use");

endmodule

// ===== hdl/ptfe_rsp_buf.sv =====
`timescale 1ns / 1ps
// ptfe_rsp_buf: output register of the result channel, one beat deep
// depends on ptfe_pkg

module ptfe_rsp_buf (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  ptfe_pkg::rsp_beat_type beat_in,
   output logic                   free,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [2:0]             rsp_status,
   output logic [7:0]             rsp_read_byte,
   output logic                   rsp_byte_valid,
   output logic                   rsp_last,
   output logic [2:0]             rsp_alloc_index,
   output logic                   rsp_write_done
);
   import ptfe_pkg::*;

   logic         valid_ff, valid_in;
   rsp_beat_type beat_ff;

   assign free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (push) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         beat_ff <= beat_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_status      = beat_ff.status;
   assign rsp_read_byte   = beat_ff.read_byte;
   assign rsp_byte_valid  = beat_ff.byte_valid;
   assign rsp_last        = beat_ff.last;
   assign rsp_alloc_index = beat_ff.alloc_index;
   assign rsp_write_done  = beat_ff.write_done;

endmodule
